FILE: hw/rtl/matrix4_inverse_singular_check_defines.svh
// assertion macros for the 4x4 inverse block and its port checker
// no dependencies; included by the checker file
`ifndef MATRIX4_INVERSE_SINGULAR_CHECK_DEFINES_SVH
`define MATRIX4_INVERSE_SINGULAR_CHECK_DEFINES_SVH

// property checked on every rising edge outside reset
`define M4I_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("m4inv assertion failed");

// a signal holds across a cycle in which cond is true
`define M4I_ASSERT_HOLD(name, cond, sig) \
  `M4I_ASSERT(name, cond |=> $stable(sig))

`endif

FILE: hw/rtl/m4inv_pkg.sv
// shared types and constants of the 4x4 adjugate inverse
// no dependencies
package m4inv_pkg;

  localparam int unsigned EW = 14;  // entry width, q2.12
  localparam int unsigned CW = 44;  // cofactor width, signed
  localparam int unsigned DW = 60;  // determinant width, signed
  localparam int unsigned QW = 33;  // quotient bits kept by the divider
  localparam int unsigned VW = 32;  // result width, q16.16

  typedef enum logic [3:0] {
    S_LOAD, S_T_RD0, S_T_RD1, S_T_RD2, S_T_MUL, S_T_ACC,
    S_D_RD, S_D_MUL, S_D_ACC, S_DIV_RD, S_DIV_START, S_DIV_WAIT, S_OUT
  } state_e;

  typedef enum logic [1:0] {DV_IDLE, DV_PREP, DV_ITER, DV_FIN} div_state_e;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

  // column slots of the six permutations of a 3x3 determinant
  localparam logic [1:0] PERM_COL [6][3] = '{
    '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd1}, '{2'd1, 2'd0, 2'd2},
    '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd1, 2'd0}
  };
  localparam logic PERM_NEG [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

  // n-th index of 0..3 once s is left out
  function automatic logic [1:0] skip_idx(logic [1:0] n, logic [1:0] s);
    return (n >= s) ? n + 2'd1 : n;
  endfunction

endpackage

FILE: hw/rtl/m4inv_divider.sv
// bit-serial restoring divider: trunc(num * 2^28 / den), saturated to 32 bits
// depends on m4inv_pkg
module m4inv_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [m4inv_pkg::CW-1:0]     num_i,
  input  logic signed [m4inv_pkg::DW-1:0]     den_i,
  output logic        [m4inv_pkg::VW-1:0]     value_o,
  output m4inv_pkg::div_stat_t                stat_o
);
  import m4inv_pkg::*;

  localparam int unsigned CMP_W = DW + 4;

  div_state_e         state_q, state_d;
  logic [CW-1:0]      cm_q;
  logic [DW-2:0]      dm_q;
  logic [DW-2:0]      rem_q;
  logic [QW-1:0]      bits_q;
  logic [QW-1:0]      quo_q;
  logic [5:0]         cnt_q;
  logic               neg_q, big_q;
  logic [DW-1:0]      rem_sh;
  logic               ge;
  logic               sat;

  assign rem_sh = {rem_q, bits_q[QW-1]};
  assign ge     = rem_sh >= {1'b0, dm_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      DV_IDLE: if (start_i) state_d = DV_PREP;
      DV_PREP: state_d = DV_ITER;
      DV_ITER: if (cnt_q == 6'd1) state_d = DV_FIN;
      DV_FIN:  state_d = DV_IDLE;
      default: state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= DV_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DV_IDLE: if (start_i) begin
        cm_q  <= num_i[CW-1] ? CW'(-num_i) : CW'(num_i);
        dm_q  <= den_i[DW-1] ? (DW-1)'(-den_i) : (DW-1)'(den_i);
        neg_q <= num_i[CW-1] ^ den_i[DW-1];
      end
      DV_PREP: begin
        // quotient of 2^33 or more is clipped anyway
        big_q  <= CMP_W'(cm_q) >= {dm_q, 5'd0};
        rem_q  <= (DW-1)'(cm_q >> 5);
        bits_q <= {cm_q[4:0], 28'd0};
        quo_q  <= '0;
        cnt_q  <= 6'(QW);
      end
      DV_ITER: begin
        rem_q  <= ge ? (DW-1)'(rem_sh - {1'b0, dm_q}) : (DW-1)'(rem_sh);
        quo_q  <= {quo_q[QW-2:0], ge};
        bits_q <= {bits_q[QW-2:0], 1'b0};
        cnt_q  <= cnt_q - 6'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (neg_q) begin
      sat     = big_q | quo_q[32] | (quo_q[31] & (|quo_q[30:0]));
      value_o = sat ? 32'h8000_0000 : 32'(-quo_q[31:0]);
    end else begin
      sat     = big_q | quo_q[32] | quo_q[31];
      value_o = sat ? 32'h7FFF_FFFF : quo_q[31:0];
    end
    stat_o.done = (state_q == DV_FIN);
    stat_o.sat  = sat;
  end

endmodule

FILE: hw/rtl/matrix4_inverse_singular_check.sv
// top level of the 4x4 fixed point inverse with singular check
// depends on m4inv_pkg and m4inv_divider
//
// input channel: sixteen words of element_value_i (signed q2.12) in index
//   order 4*row+col, one per valid/ready handshake; in_ready_o is high only
//   while a matrix is being loaded
// after the sixteenth word the block works out of two memories: the matrix
//   store (16 x 14) and a cofactor store (16 x 44), both with registered reads
//   cofactors: 16 x 6 triple products, each read, multiplied and accumulated
//   determinant: row 0 times cofactor column 0
//   inverse: one serial divider, 33 quotient bits, per entry
//     (read, start, the divider run, output); no divider run when singular
// output channel: 16 words in index order, inverse_value_o in q16.16 with
//   entry_index_o, singular_o, saturated_o and last_entry_o; a zero
//   determinant gives zero values with singular_o set
// the first output word follows the cofactors, the determinant and the first division
// a new matrix is taken only after the last output word; the time is set by the
//   6-term cofactor loop and the bit-serial divider
// a stalled receiver holds the output register and the sequence waits for it
// reset clears the sequencer and the load index; store contents are unused
//   until written
module matrix4_inverse_singular_check (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [m4inv_pkg::EW-1:0]    element_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [m4inv_pkg::VW-1:0]    inverse_value_o,
  output logic        [3:0]                  entry_index_o,
  output logic                               singular_o,
  output logic                               saturated_o,
  output logic                               last_entry_o
);
  import m4inv_pkg::*;

  state_e state_q, state_d;
  logic [3:0] k_q, k_d;           // entry, cofactor or output index
  logic [2:0] perm_q, perm_d;     // permutation of the current minor

  // matrix store
  logic signed [EW-1:0] mat_mem [16];
  logic signed [EW-1:0] mat_rdata_q;
  logic [3:0]           mat_raddr;
  logic                 mat_we;

  // cofactor store
  logic signed [CW-1:0] cof_mem [16];
  logic signed [CW-1:0] cof_rdata_q;
  logic [3:0]           cof_raddr;
  logic                 cof_we;
  logic signed [CW-1:0] cof_wdata;

  // datapath registers
  logic signed [EW-1:0]   x_q, x_d;
  logic signed [2*EW-1:0] p2_q, p2_d;
  logic signed [3*EW-1:0] p3_q, p3_d;
  logic signed [CW-1:0]   acc_q, acc_d;
  logic signed [DW-3:0]   dp_q, dp_d;
  logic signed [DW-1:0]   det_q, det_d;
  logic signed [CW-1:0]   term;
  logic                   term_neg;
  logic                   det_zero;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [VW-1:0]        out_val_q, out_val_d;
  logic [3:0]           out_idx_q, out_idx_d;
  logic                 out_sing_q, out_sing_d;
  logic                 out_sat_q, out_sat_d;

  // divider
  logic                 div_start;
  logic [VW-1:0]        div_value;
  div_stat_t            div_stat;

  m4inv_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (cof_rdata_q),
    .den_i   (det_q),
    .value_o (div_value),
    .stat_o  (div_stat)
  );

  // minor without row j and column i, cofactor k = 4i + j
  function automatic logic [3:0] term_addr(logic [3:0] k, logic [2:0] p, logic [1:0] f);
    return {skip_idx(f, k[1:0]), skip_idx(PERM_COL[p][f], k[3:2])};
  endfunction

  assign term_neg = PERM_NEG[perm_q] ^ k_q[0] ^ k_q[2];
  assign term     = {{(CW-3*EW){p3_q[3*EW-1]}}, p3_q};
  assign det_zero = (det_q == '0);

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    perm_d      = perm_q;
    x_d         = x_q;
    p2_d        = p2_q;
    p3_d        = p3_q;
    acc_d       = acc_q;
    dp_d        = dp_q;
    det_d       = det_q;
    mat_raddr   = k_q;
    mat_we      = 1'b0;
    cof_raddr   = k_q;
    cof_we      = 1'b0;
    cof_wdata   = '0;
    div_start   = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_val_d   = out_val_q;
    out_idx_d   = out_idx_q;
    out_sing_d  = out_sing_q;
    out_sat_d   = out_sat_q;

    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mat_we = 1'b1;
          k_d    = k_q + 4'd1;
          if (k_q == 4'd15) begin
            perm_d  = '0;
            acc_d   = '0;
            det_d   = '0;
            state_d = S_T_RD0;
          end
        end
      end
      S_T_RD0: begin
        mat_raddr = term_addr(k_q, perm_q, 2'd0);
        state_d   = S_T_RD1;
      end
      S_T_RD1: begin
        mat_raddr = term_addr(k_q, perm_q, 2'd1);
        x_d       = mat_rdata_q;
        state_d   = S_T_RD2;
      end
      S_T_RD2: begin
        mat_raddr = term_addr(k_q, perm_q, 2'd2);
        p2_d      = x_q * mat_rdata_q;
        state_d   = S_T_MUL;
      end
      S_T_MUL: begin
        p3_d    = p2_q * mat_rdata_q;
        state_d = S_T_ACC;
      end
      S_T_ACC: begin
        acc_d = term_neg ? acc_q - term : acc_q + term;
        if (perm_q == 3'd5) begin
          // minor done: store the signed cofactor
          cof_we    = 1'b1;
          cof_wdata = acc_d;
          acc_d     = '0;
          perm_d    = '0;
          k_d       = k_q + 4'd1;
          state_d   = (k_q == 4'd15) ? S_D_RD : S_T_RD0;
        end else begin
          perm_d  = perm_q + 3'd1;
          state_d = S_T_RD0;
        end
      end
      S_D_RD: begin
        // a[0][i] against cofactor 4i
        mat_raddr = {2'd0, k_q[1:0]};
        cof_raddr = {k_q[1:0], 2'd0};
        state_d   = S_D_MUL;
      end
      S_D_MUL: begin
        dp_d    = mat_rdata_q * cof_rdata_q;
        state_d = S_D_ACC;
      end
      S_D_ACC: begin
        det_d = det_q + {{2{dp_q[DW-3]}}, dp_q};
        k_d   = k_q + 4'd1;
        if (k_q == 4'd3) begin
          k_d     = '0;
          state_d = S_DIV_RD;
        end else begin
          state_d = S_D_RD;
        end
      end
      S_DIV_RD: state_d = S_DIV_START;
      S_DIV_START: begin
        if (det_zero) begin
          state_d = S_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: if (div_stat.done) state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_val_d   = det_zero ? '0 : div_value;
          out_sat_d   = ~det_zero & div_stat.sat;
          out_sing_d  = det_zero;
          out_idx_d   = k_q;
          k_d         = k_q + 4'd1;
          state_d     = (k_q == 4'd15) ? S_LOAD : S_DIV_RD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      k_q         <= '0;
      perm_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      perm_q      <= perm_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    p2_q       <= p2_d;
    p3_q       <= p3_d;
    acc_q      <= acc_d;
    dp_q       <= dp_d;
    det_q      <= det_d;
    out_val_q  <= out_val_d;
    out_idx_q  <= out_idx_d;
    out_sing_q <= out_sing_d;
    out_sat_q  <= out_sat_d;
  end

  // memories, one write and one registered read port each
  always_ff @(posedge clk_i) begin
    if (mat_we) mat_mem[k_q] <= element_value_i;
    mat_rdata_q <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cof_we) cof_mem[k_q] <= cof_wdata;
    cof_rdata_q <= cof_mem[cof_raddr];
  end

  assign out_valid_o     = out_valid_q;
  assign inverse_value_o = out_val_q;
  assign entry_index_o   = out_idx_q;
  assign singular_o      = out_sing_q;
  assign saturated_o     = out_sat_q;
  assign last_entry_o    = (out_idx_q == 4'd15);

endmodule

FILE: hw/rtl/m4inv_checker.sv
// port-level checker for the 4x4 inverse block, bound to the top level
// depends on m4inv_pkg and matrix4_inverse_singular_check_defines.svh
`include "matrix4_inverse_singular_check_defines.svh"

module m4inv_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic signed [m4inv_pkg::EW-1:0]    element_value_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [m4inv_pkg::VW-1:0]    inverse_value_o,
  input logic        [3:0]                  entry_index_o,
  input logic                               singular_o,
  input logic                               saturated_o,
  input logic                               last_entry_o
);
  import m4inv_pkg::*;

  `M4I_ASSERT_HOLD(a_out_hold, out_valid_o && !out_ready_i, inverse_value_o)
  `M4I_ASSERT(a_sing_zero, out_valid_o && singular_o |-> inverse_value_o == '0 && !saturated_o)
  `M4I_ASSERT(a_sat_rail, out_valid_o && saturated_o |-> inverse_value_o == 32'sh7FFF_FFFF || inverse_value_o == 32'sh8000_0000)
  `M4I_ASSERT(a_last_idx, out_valid_o && last_entry_o |-> entry_index_o == 4'd15)

endmodule

bind matrix4_inverse_singular_check m4inv_checker u_m4inv_checker (.*);
